>>> hw/rtl/i2c_master_register_access_defines.svh
// assertion macros for the i2c register access rtl
// no dependencies; files that assert include this header by name
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, off during reset
`define I2CM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// next-cycle implication, off during reset
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`else

`define I2CM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/i2cm_pkg.sv
// shared types and constants for the i2c register access master
// no dependencies
package i2cm_pkg;

    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic CFG_IDX_ACK_LIMIT = 1'b0;
    localparam logic CFG_IDX_RECOVERY  = 1'b1;

    localparam logic [7:0]  ACK_LIMIT_RST = 8'd250;
    localparam logic [15:0] RECOVERY_RST  = 16'd2500;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] target_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic       tx_request;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
    } t_res;

endpackage

>>> hw/rtl/i2cm_cmd_if.sv
// valid/ready channel carrying one tick beat into the master
// depends on i2cm_pkg
interface i2cm_cmd_if;
    logic              valid;
    logic              ready;
    i2cm_pkg::t_cmd    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/i2cm_res_if.sv
// valid/ready channel carrying one result beat out of the master
// depends on i2cm_pkg
interface i2cm_res_if;
    logic              valid;
    logic              ready;
    i2cm_pkg::t_res    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/i2cm_fsm.sv
// half-bit phase sequencer: bus state, shifting, ack timeout, write recovery
// depends on i2cm_pkg and i2c_master_register_access_defines.svh
`include "i2c_master_register_access_defines.svh"

module i2cm_fsm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  i2cm_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_ack_limit,
    input  logic [15:0]    i_recovery_ticks,
    output i2cm_pkg::t_res o_res
);

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_START_HOLD = 5'd1,
        PH_START_LOW  = 5'd2,
        PH_TX_LOW     = 5'd3,
        PH_TX_HIGH    = 5'd4,
        PH_TACK_LOW   = 5'd5,
        PH_TACK_HIGH  = 5'd6,
        PH_RX_LOW     = 5'd7,
        PH_RX_HIGH    = 5'd8,
        PH_MACK_LOW   = 5'd9,
        PH_MACK_HIGH  = 5'd10,
        PH_RS_LOW     = 5'd11,
        PH_RS_HIGH    = 5'd12,
        PH_STOP_LOW   = 5'd13,
        PH_STOP_HIGH  = 5'd14,
        PH_RECOVERY   = 5'd15
    } t_phase;

    typedef enum logic [1:0] {
        STG_DEV_W = 2'd0,
        STG_REG   = 2'd1,
        STG_DEV_R = 2'd2,
        STG_DATA  = 2'd3
    } t_stage;

    t_phase      r_phase, n_phase;
    t_stage      r_stage, n_stage;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_ack_timer, n_ack_timer;
    logic [15:0] r_rec_timer, n_rec_timer;
    logic [7:0]  r_latched_dev, n_latched_dev;
    logic [7:0]  r_latched_reg, n_latched_reg;
    logic [7:0]  r_latched_len, n_latched_len;
    logic        r_read_mode, n_read_mode;
    logic        r_aborted, n_aborted;

    logic [8:0]  eff_len;
    logic        last_byte;

    assign eff_len   = (r_latched_len == 8'd0) ? 9'd1 : {1'b0, r_latched_len};
    assign last_byte = (({1'b0, r_byte_count} + 9'd1) >= eff_len);

    always_comb begin
        logic [7:0]  shifted;
        logic [3:0]  bit_inc;
        logic [7:0]  byte_next;
        logic [15:0] rec_dec;
        logic        keep_busy;

        shifted   = {r_shift[6:0], 1'b0};
        bit_inc   = r_bit_count + 4'd1;
        byte_next = r_byte_count + 8'd1;
        rec_dec   = r_rec_timer - 16'd1;
        keep_busy = 1'b0;

        n_phase       = PH_IDLE;
        n_stage       = r_stage;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_byte_count  = r_byte_count;
        n_ack_timer   = r_ack_timer;
        n_rec_timer   = r_rec_timer;
        n_latched_dev = r_latched_dev;
        n_latched_reg = r_latched_reg;
        n_latched_len = r_latched_len;
        n_read_mode   = r_read_mode;
        n_aborted     = r_aborted;

        o_res         = '0;
        o_res.scl_out = 1'b1;
        o_res.sda_out = 1'b1;

        case (r_phase)
            PH_START_HOLD: begin
                n_phase       = PH_START_LOW;
                o_res.scl_out = 1'b0;
                o_res.sda_out = 1'b0;
                n_bit_count   = 4'd0;
            end
            PH_START_LOW: begin
                n_phase       = PH_TX_LOW;
                o_res.scl_out = 1'b0;
                o_res.sda_out = r_shift[7];
            end
            PH_TX_LOW: begin
                n_phase       = PH_TX_HIGH;
                o_res.scl_out = 1'b1;
                o_res.sda_out = r_shift[7];
            end
            PH_TX_HIGH: begin
                n_shift       = shifted;
                n_bit_count   = bit_inc;
                o_res.scl_out = 1'b0;
                if (bit_inc >= 4'd8) begin
                    n_phase       = PH_TACK_LOW;
                    o_res.sda_out = 1'b1;
                    n_ack_timer   = 8'd0;
                end else begin
                    n_phase       = PH_TX_LOW;
                    o_res.sda_out = shifted[7];
                end
            end
            PH_TACK_LOW: begin
                n_phase = PH_TACK_HIGH;
            end
            PH_TACK_HIGH: begin
                if (i_cmd.sda_in) begin
                    if (r_ack_timer >= i_ack_limit) begin
                        n_aborted     = 1'b1;
                        n_phase       = PH_STOP_LOW;
                        o_res.scl_out = 1'b0;
                        o_res.sda_out = 1'b0;
                    end else begin
                        n_ack_timer = r_ack_timer + 8'd1;
                        n_phase     = PH_TACK_HIGH;
                    end
                end else begin
                    o_res.scl_out = 1'b0;
                    n_bit_count   = 4'd0;
                    if (r_stage == STG_DEV_W) begin
                        n_stage       = STG_REG;
                        n_shift       = r_latched_reg;
                        n_phase       = PH_TX_LOW;
                        o_res.sda_out = r_latched_reg[7];
                    end else if (r_stage == STG_REG && r_read_mode) begin
                        n_phase = PH_RS_LOW;
                    end else if (r_stage == STG_DEV_R) begin
                        n_shift      = 8'd0;
                        n_byte_count = 8'd0;
                        n_phase      = PH_RX_LOW;
                    end else begin
                        // write: count acked data bytes, then send or stop
                        if (r_stage != STG_DATA) begin
                            byte_next = 8'd0;
                        end
                        n_byte_count = byte_next;
                        n_stage      = STG_DATA;
                        if ({1'b0, byte_next} >= eff_len) begin
                            n_phase       = PH_STOP_LOW;
                            o_res.sda_out = 1'b0;
                        end else begin
                            n_shift          = i_cmd.tx_byte;
                            o_res.tx_request = 1'b1;
                            n_phase          = PH_TX_LOW;
                            o_res.sda_out    = i_cmd.tx_byte[7];
                        end
                    end
                end
            end
            PH_RS_LOW: begin
                n_phase = PH_RS_HIGH;
            end
            PH_RS_HIGH: begin
                n_stage       = STG_DEV_R;
                n_shift       = r_latched_dev | 8'h01;
                n_phase       = PH_START_HOLD;
                o_res.sda_out = 1'b0;
            end
            PH_RX_LOW: begin
                n_phase = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                n_shift       = {r_shift[6:0], i_cmd.sda_in};
                n_bit_count   = bit_inc;
                o_res.scl_out = 1'b0;
                if (bit_inc >= 4'd8) begin
                    o_res.rx_valid = 1'b1;
                    o_res.rx_byte  = {r_shift[6:0], i_cmd.sda_in};
                    o_res.rx_last  = last_byte;
                    o_res.sda_out  = last_byte;
                    n_phase        = PH_MACK_LOW;
                end else begin
                    n_phase = PH_RX_LOW;
                end
            end
            PH_MACK_LOW: begin
                n_phase       = PH_MACK_HIGH;
                o_res.sda_out = last_byte;
            end
            PH_MACK_HIGH: begin
                n_byte_count  = byte_next;
                o_res.scl_out = 1'b0;
                if ({1'b0, byte_next} >= eff_len) begin
                    n_phase       = PH_STOP_LOW;
                    o_res.sda_out = 1'b0;
                end else begin
                    n_bit_count = 4'd0;
                    n_shift     = 8'd0;
                    n_phase     = PH_RX_LOW;
                end
            end
            PH_STOP_LOW: begin
                n_phase       = PH_STOP_HIGH;
                o_res.sda_out = 1'b0;
            end
            PH_STOP_HIGH: begin
                o_res.done_res  = 1'b1;
                o_res.ack_error = r_aborted;
                if (!r_read_mode && !r_aborted && i_recovery_ticks != 16'd0) begin
                    n_rec_timer = i_recovery_ticks;
                    n_phase     = PH_RECOVERY;
                end
            end
            PH_RECOVERY: begin
                n_rec_timer = rec_dec;
                keep_busy   = 1'b1;
                n_phase     = (rec_dec == 16'd0) ? PH_IDLE : PH_RECOVERY;
            end
            default: begin
                if ((i_cmd.opcode == i2cm_pkg::OP_READ) ||
                    (i_cmd.opcode == i2cm_pkg::OP_WRITE)) begin
                    n_latched_dev = i_cmd.target_addr;
                    n_latched_reg = i_cmd.reg_addr;
                    n_latched_len = i_cmd.length;
                    n_read_mode   = (i_cmd.opcode == i2cm_pkg::OP_READ);
                    n_shift       = i_cmd.target_addr & 8'hFE;
                    n_stage       = STG_DEV_W;
                    n_bit_count   = 4'd0;
                    n_byte_count  = 8'd0;
                    n_ack_timer   = 8'd0;
                    n_aborted     = 1'b0;
                    n_phase       = PH_START_HOLD;
                    o_res.sda_out = 1'b0;
                end
            end
        endcase

        o_res.busy_res = (n_phase != PH_IDLE) || keep_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_stage       <= STG_DEV_W;
            r_bit_count   <= 4'd0;
            r_shift       <= 8'd0;
            r_byte_count  <= 8'd0;
            r_ack_timer   <= 8'd0;
            r_rec_timer   <= 16'd0;
            r_latched_dev <= 8'd0;
            r_latched_reg <= 8'd0;
            r_latched_len <= 8'd0;
            r_read_mode   <= 1'b0;
            r_aborted     <= 1'b0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_stage       <= n_stage;
            r_bit_count   <= n_bit_count;
            r_shift       <= n_shift;
            r_byte_count  <= n_byte_count;
            r_ack_timer   <= n_ack_timer;
            r_rec_timer   <= n_rec_timer;
            r_latched_dev <= n_latched_dev;
            r_latched_reg <= n_latched_reg;
            r_latched_len <= n_latched_len;
            r_read_mode   <= n_read_mode;
            r_aborted     <= n_aborted;
        end
    end

    `I2CM_ASSERT_IMPLY(a_recovery_after_clean_write, i_clk, i_rst_n, r_phase == PH_RECOVERY, !r_read_mode && !r_aborted)
    `I2CM_ASSERT_IMPLY(a_rx_byte_in_range, i_clk, i_rst_n, r_phase == PH_RX_LOW, {1'b0, r_byte_count} < eff_len)
    `I2CM_ASSERT_NEXT(a_rx_then_master_ack, i_clk, i_rst_n, i_adv && o_res.rx_valid, r_phase == PH_MACK_LOW)
    `I2CM_ASSERT_NEXT(a_ack_timer_counts, i_clk, i_rst_n, i_adv && r_phase == PH_TACK_HIGH && i_cmd.sda_in && r_ack_timer < i_ack_limit, r_ack_timer == 8'($past(r_ack_timer) + 8'd1))

endmodule

>>> hw/rtl/i2c_master_register_access.sv
// i2c master for device register reads and writes. each accepted command beat is one
// half-bit tick of the bus and yields exactly one result beat with the pin levels and
// status for that tick. a beat is taken every cycle while the result register is free
// or being drained, so the sustained rate is one tick per clock and each result is
// registered; the rate is set by the single result register behind the phase sequencer.
// the ack timeout and post-write recovery are set through the config write port.
// depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and i2cm_fsm
module i2c_master_register_access (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    i2cm_cmd_if.sink                        i_cmd,
    i2cm_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]     r_ack_limit;
    logic [15:0]    r_recovery_ticks;
    logic           r_res_valid;
    i2cm_pkg::t_res r_res;

    logic           adv;
    i2cm_pkg::t_res step_res;

    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign adv         = i_cmd.valid && i_cmd.ready;

    i2cm_fsm u_fsm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_cmd            (i_cmd.payload),
        .i_ack_limit      (r_ack_limit),
        .i_recovery_ticks (r_recovery_ticks),
        .o_res            (step_res)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_limit      <= i2cm_pkg::ACK_LIMIT_RST;
            r_recovery_ticks <= i2cm_pkg::RECOVERY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cm_pkg::CFG_IDX_ACK_LIMIT: r_ack_limit      <= i_cfg_data[7:0];
                i2cm_pkg::CFG_IDX_RECOVERY:  r_recovery_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (adv) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= step_res;
        end
    end

    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

endmodule

>>> tb/sv/i2c_tick_checker.sv
`timescale 1ns / 1ps
// scoreboard for the i2c register access master: mirrors the bus sequencer to
// predict every result beat from the accepted tick beats and config writes
// depends on i2cm_pkg, i2cm_cmd_if and i2cm_res_if
module i2c_tick_checker
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    i2cm_cmd_if                   i_cmd,
    i2cm_res_if                   i_res,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_HOLD, PH_START_LOW, PH_TX_LOW, PH_TX_HIGH,
        PH_TACK_LOW, PH_TACK_HIGH, PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW,
        PH_MACK_HIGH, PH_RS_LOW, PH_RS_HIGH, PH_STOP_LOW, PH_STOP_HIGH,
        PH_RECOVERY
    } t_bus_phase;

    typedef enum logic [1:0] {STG_DEV_W, STG_REG, STG_DEV_R, STG_DATA} t_addr_stage;

    logic [7:0]  ack_limit;
    logic [15:0] recovery_ticks;

    t_bus_phase  phase;
    t_addr_stage stage;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [7:0]  byte_cnt;
    logic [7:0]  ack_ticks;
    logic [15:0] recovery_left;
    logic [7:0]  dev_q;
    logic [7:0]  reg_q;
    logic [7:0]  len_q;
    logic        reading;
    logic        aborting;

    t_res tick_results_due[$];
    t_res want;
    int   beat_no;

    function automatic t_res step_bus(input t_cmd c);
        t_res       r;
        t_bus_phase nxt;
        logic       keep;
        int         span;
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        nxt = PH_IDLE;
        keep = 1'b0;
        span = (len_q == 8'd0) ? 1 : int'(len_q);
        case (phase)
            PH_START_HOLD: begin
                nxt = PH_START_LOW;
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                bit_cnt = 4'd0;
            end
            PH_START_LOW, PH_TX_LOW: begin
                nxt = (phase == PH_TX_LOW) ? PH_TX_HIGH : PH_TX_LOW;
                r.scl_out = (nxt == PH_TX_HIGH);
                r.sda_out = shifter[7];
            end
            PH_TX_HIGH: begin
                shifter = shifter << 1;
                bit_cnt = bit_cnt + 4'd1;
                r.scl_out = 1'b0;
                if (bit_cnt >= 4'd8) begin
                    nxt = PH_TACK_LOW;
                    ack_ticks = 8'd0;
                end else begin
                    nxt = PH_TX_LOW;
                    r.sda_out = shifter[7];
                end
            end
            PH_TACK_LOW: nxt = PH_TACK_HIGH;
            PH_TACK_HIGH: begin
                if (c.sda_in) begin
                    if (ack_ticks >= ack_limit) begin
                        aborting = 1'b1;
                        nxt = PH_STOP_LOW;
                        r.scl_out = 1'b0;
                        r.sda_out = 1'b0;
                    end else begin
                        ack_ticks = ack_ticks + 8'd1;
                        nxt = PH_TACK_HIGH;
                    end
                end else begin
                    r.scl_out = 1'b0;
                    bit_cnt = 4'd0;
                    if (stage == STG_DEV_W) begin
                        stage = STG_REG;
                        shifter = reg_q;
                        nxt = PH_TX_LOW;
                        r.sda_out = shifter[7];
                    end else if (stage == STG_REG && reading) begin
                        nxt = PH_RS_LOW;
                    end else if (stage == STG_DEV_R) begin
                        shifter = 8'd0;
                        byte_cnt = 8'd0;
                        nxt = PH_RX_LOW;
                    end else begin
                        byte_cnt = (stage == STG_DATA) ? byte_cnt + 8'd1 : 8'd0;
                        stage = STG_DATA;
                        if (int'(byte_cnt) >= span) begin
                            nxt = PH_STOP_LOW;
                            r.sda_out = 1'b0;
                        end else begin
                            shifter = c.tx_byte;
                            r.tx_request = 1'b1;
                            nxt = PH_TX_LOW;
                            r.sda_out = shifter[7];
                        end
                    end
                end
            end
            PH_RS_LOW: nxt = PH_RS_HIGH;
            PH_RS_HIGH: begin
                stage = STG_DEV_R;
                shifter = dev_q | 8'h01;
                nxt = PH_START_HOLD;
                r.sda_out = 1'b0;
            end
            PH_RX_LOW: nxt = PH_RX_HIGH;
            PH_RX_HIGH: begin
                shifter = {shifter[6:0], c.sda_in};
                bit_cnt = bit_cnt + 4'd1;
                r.scl_out = 1'b0;
                if (bit_cnt >= 4'd8) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte = shifter;
                    r.rx_last = (int'(byte_cnt) + 1 >= span);
                    nxt = PH_MACK_LOW;
                    r.sda_out = r.rx_last;
                end else begin
                    nxt = PH_RX_LOW;
                end
            end
            PH_MACK_LOW: begin
                nxt = PH_MACK_HIGH;
                r.sda_out = (int'(byte_cnt) + 1 >= span);
            end
            PH_MACK_HIGH: begin
                byte_cnt = byte_cnt + 8'd1;
                r.scl_out = 1'b0;
                if (int'(byte_cnt) >= span) begin
                    nxt = PH_STOP_LOW;
                    r.sda_out = 1'b0;
                end else begin
                    bit_cnt = 4'd0;
                    shifter = 8'd0;
                    nxt = PH_RX_LOW;
                end
            end
            PH_STOP_LOW: begin
                nxt = PH_STOP_HIGH;
                r.sda_out = 1'b0;
            end
            PH_STOP_HIGH: begin
                r.done_res = 1'b1;
                r.ack_error = aborting;
                if (!reading && !aborting && recovery_ticks != 16'd0) begin
                    recovery_left = recovery_ticks;
                    nxt = PH_RECOVERY;
                end
            end
            PH_RECOVERY: begin
                recovery_left = recovery_left - 16'd1;
                keep = 1'b1;
                nxt = (recovery_left == 16'd0) ? PH_IDLE : PH_RECOVERY;
            end
            default: begin
                if (c.opcode == OP_READ || c.opcode == OP_WRITE) begin
                    dev_q = c.target_addr;
                    reg_q = c.reg_addr;
                    len_q = c.length;
                    reading = (c.opcode == OP_READ);
                    shifter = c.target_addr & 8'hFE;
                    stage = STG_DEV_W;
                    bit_cnt = 4'd0;
                    byte_cnt = 8'd0;
                    ack_ticks = 8'd0;
                    aborting = 1'b0;
                    nxt = PH_START_HOLD;
                    r.sda_out = 1'b0;
                end
            end
        endcase
        phase = nxt;
        r.busy_res = (nxt != PH_IDLE) || keep;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ack_limit = ACK_LIMIT_RST;
            recovery_ticks = RECOVERY_RST;
            phase = PH_IDLE;
            stage = STG_DEV_W;
            bit_cnt = '0;
            shifter = '0;
            byte_cnt = '0;
            ack_ticks = '0;
            recovery_left = '0;
            dev_q = '0;
            reg_q = '0;
            len_q = '0;
            reading = 1'b0;
            aborting = 1'b0;
            tick_results_due.delete();
            beat_no = 0;
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_ACK_LIMIT) ack_limit = i_cfg_data[7:0];
                else recovery_ticks = i_cfg_data;
            end
            if (i_cmd.valid && i_cmd.ready) tick_results_due.push_back(step_bus(i_cmd.payload));
            if (i_res.valid && i_res.ready) begin
                beat_no++;
                if (tick_results_due.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("beat %0d arrived with no tick outstanding", beat_no);
                end else begin
                    want = tick_results_due.pop_front();
                    if (i_res.payload !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("beat %0d expected scl=%b sda=%b rx=%02h v=%b last=%b %s",
                                     beat_no, want.scl_out, want.sda_out, want.rx_byte,
                                     want.rx_valid, want.rx_last, "");
                            $display("    txreq=%b busy=%b done=%b err=%b",
                                     want.tx_request, want.busy_res, want.done_res,
                                     want.ack_error);
                            $display("beat %0d got      scl=%b sda=%b rx=%02h v=%b last=%b",
                                     beat_no, i_res.payload.scl_out, i_res.payload.sda_out,
                                     i_res.payload.rx_byte, i_res.payload.rx_valid,
                                     i_res.payload.rx_last);
                            $display("    txreq=%b busy=%b done=%b err=%b",
                                     i_res.payload.tx_request, i_res.payload.busy_res,
                                     i_res.payload.done_res, i_res.payload.ack_error);
                        end
                    end
                end
            end
        end
        o_outstanding = tick_results_due.size();
    end

endmodule

>>> tb/sv/i2c_master_register_access_test.sv
`timescale 1ns / 1ps
// top of the i2c register access master test: clock, reset, tick stimulus acting
// as a slave on sda, config writes and the verdict; checking is done by i2c_tick_checker
// depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if, i2c_tick_checker and the rtl
module i2c_master_register_access_test;
    import i2cm_pkg::*;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_PLAIN_TICK = 2'd3;
    localparam int RANDOM_ITEMS   = 650;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum logic [1:0] {SDA_LOW, SDA_RANDOM, SDA_MOSTLY_HIGH, SDA_HIGH} t_sda_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic                  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2cm_cmd_if cmd_ch ();
    i2cm_res_if res_ch ();

    logic rx_open = 1'b0;
    assign res_ch.ready = rx_open;

    int   n_issued = 0;
    int   n_recv = 0;
    int   last_idle_seq = 0;
    int   rx_stall = 0;
    int   idle_cycles = 0;
    logic last_busy = 1'b0;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;
    int   mismatches;
    int   outstanding;

    i2c_master_register_access uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    i2c_tick_checker tick_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .i_res         (res_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side bookkeeping and receiver stalls
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready) begin
            n_recv <= n_recv + 1;
            last_busy <= res_ch.payload.busy_res;
            if (!res_ch.payload.busy_res) last_idle_seq <= n_recv + 1;
            rx_stall <= rx_burst ? 0 : $urandom_range(0, 3);
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
        end
    end

    always @(negedge i_clk) rx_open <= (rx_stall == 0);

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic t_cmd make_tick(input t_sda_mode mode);
        t_cmd beat;
        beat.target_addr = 8'($urandom);
        beat.reg_addr = 8'($urandom);
        beat.length = 8'($urandom);
        beat.tx_byte = 8'($urandom);
        beat.opcode = ($urandom_range(0, 7) == 0) ? OP_PLAIN_TICK : OP_TICK;
        case (mode)
            SDA_LOW:         beat.sda_in = 1'b0;
            SDA_RANDOM:      beat.sda_in = 1'($urandom_range(0, 1));
            SDA_MOSTLY_HIGH: beat.sda_in = ($urandom_range(0, 15) != 0);
            default:         beat.sda_in = 1'b1;
        endcase
        return beat;
    endfunction

    // noisy beats may carry a command while the bus is known to be busy
    task automatic push_beat(input t_cmd beat, input bit noisy);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            @(negedge i_clk) cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        if (noisy && n_recv == n_issued && last_busy && $urandom_range(0, 3) == 0)
            beat.opcode = 2'($urandom_range(0, 3));
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= beat;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        n_issued++;
    endtask

    task automatic wait_drained;
        @(negedge i_clk) cmd_ch.valid <= 1'b0;
        while (n_recv != n_issued) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] limit, input logic [15:0] recovery);
        wait_drained();
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_IDX_ACK_LIMIT;
        cfg_data <= {8'h00, limit};
        @(negedge i_clk);
        cfg_idx <= CFG_IDX_RECOVERY;
        cfg_data <= recovery;
        @(negedge i_clk) cfg_we <= 1'b0;
    endtask

    // one command, then ticks until the bus has gone idle again
    task automatic run_transfer(input logic [1:0] op, input logic [7:0] dev,
                                input logic [7:0] reg_a, input logic [7:0] len,
                                input t_sda_mode mode);
        t_cmd beat;
        int   cmd_idx;
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        beat = make_tick(mode);
        beat.opcode = op;
        beat.target_addr = dev;
        beat.reg_addr = reg_a;
        beat.length = len;
        push_beat(beat, 1'b0);
        cmd_idx = n_issued;
        while (last_idle_seq < cmd_idx) push_beat(make_tick(mode), 1'b1);
    endtask

    initial begin
        t_cmd       beat;
        int         base;
        int         txn;
        int         pick;
        logic [1:0] op;
        logic [7:0] len;
        logic [7:0] limit;
        logic [15:0] recovery;
        t_sda_mode  mode;

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_IDX_ACK_LIMIT;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // idle bus with both tick codes
        beat = make_tick(SDA_RANDOM);
        beat.opcode = OP_TICK;
        push_beat(beat, 1'b0);
        beat = make_tick(SDA_RANDOM);
        beat.opcode = OP_PLAIN_TICK;
        push_beat(beat, 1'b0);

        // tightest ack window, no recovery
        set_config(8'd0, 16'd0);
        run_transfer(OP_READ, 8'hFF, 8'h00, 8'd0, SDA_LOW);
        run_transfer(OP_WRITE, 8'h00, 8'hFF, 8'd1, SDA_LOW);
        run_transfer(OP_WRITE, 8'($urandom), 8'($urandom), 8'd255, SDA_RANDOM);
        run_transfer(OP_READ, 8'hA5, 8'h5A, 8'd2, SDA_HIGH);

        // widest ack window, longest recovery, which only clean writes reach
        set_config(8'd255, 16'hFFFF);
        run_transfer(OP_READ, 8'($urandom), 8'($urandom), 8'd3, SDA_RANDOM);
        run_transfer(OP_WRITE, 8'($urandom), 8'($urandom), 8'd1, SDA_HIGH);

        set_config(ACK_LIMIT_RST, 16'd1);
        run_transfer(OP_WRITE, 8'h5A, 8'hA5, 8'd2, SDA_RANDOM);
        run_transfer(OP_READ, 8'($urandom), 8'($urandom), 8'd1, SDA_MOSTLY_HIGH);

        base = n_issued;
        txn = 0;
        while (n_issued - base < RANDOM_ITEMS) begin
            if (txn % 5 == 0) begin
                pick = $urandom_range(0, 5);
                limit = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 6));
                pick = $urandom_range(0, 3);
                recovery = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1
                                                             : 16'($urandom_range(2, 40));
                set_config(limit, recovery);
            end
            pick = $urandom_range(0, 15);
            if (pick == 0) op = ($urandom_range(0, 1) == 0) ? OP_TICK : OP_PLAIN_TICK;
            else op = (pick < 8) ? OP_READ : OP_WRITE;
            pick = $urandom_range(0, 19);
            mode = (pick < 12) ? SDA_RANDOM : (pick < 15) ? SDA_LOW
                 : (pick < 18) ? SDA_MOSTLY_HIGH : SDA_HIGH;
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                len = 8'd0;
            end else if (pick < 18) begin
                len = 8'($urandom_range(1, 3));
            end else if (op == OP_WRITE) begin
                len = 8'($urandom_range(4, 16));
                mode = SDA_MOSTLY_HIGH;
            end else begin
                len = 8'($urandom_range(4, 8));
            end
            run_transfer(op, 8'($urandom), 8'($urandom), len, mode);
            txn++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_cmd_if.sv
hw/rtl/i2cm_res_if.sv
hw/rtl/i2cm_fsm.sv
hw/rtl/i2c_master_register_access.sv
tb/sv/i2c_tick_checker.sv
tb/sv/i2c_master_register_access_test.sv
